[design/frs_pkg.sv]
// frs_pkg: shared types and codes of the fault recovery supervisor
// no dependencies; imported by every module of the block
`default_nettype none

package frs_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned TALLY_W = 8;

    localparam logic [TIME_W-1:0]  AUTO_DELAY_RST = 32'd2000;
    localparam logic [TIME_W-1:0]  WINDOW_RST     = 32'd30000;
    localparam logic [TALLY_W-1:0] RETRY_MAX_RST  = 8'd3;
    localparam logic [TALLY_W-1:0] TALLY_SAT      = 8'd255;

    typedef enum logic [1:0] {
        CFG_AUTO_DELAY = 2'd0,
        CFG_WINDOW     = 2'd1,
        CFG_RETRY_MAX  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_FAULT   = 2'd0,
        OP_TICK    = 2'd1,
        OP_CONFIRM = 2'd2
    } op_t;

    typedef enum logic [CODE_W-1:0] {
        FC_NONE        = 4'd0,
        FC_OVERCURRENT = 4'd1,
        FC_IBUS_LOST   = 4'd2,
        FC_COMMS       = 4'd3,
        FC_DRIVE       = 4'd4,
        FC_BLADE_TMO   = 4'd5,
        FC_BLACK_FIRST = 4'd6,
        FC_BLACK_LAST  = 4'd11
    } fault_code_t;

    typedef enum logic [3:0] {
        MODE_NONE    = 4'b0001,
        MODE_AUTO    = 4'b0010,
        MODE_MANUAL  = 4'b0100,
        MODE_LOCKOUT = 4'b1000
    } mode_t;

    localparam logic [1:0] MODE_CODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_CODE_AUTO    = 2'd1;
    localparam logic [1:0] MODE_CODE_MANUAL  = 2'd2;
    localparam logic [1:0] MODE_CODE_LOCKOUT = 2'd3;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_BLACKLIST = 3'd1,
        EV_RETRY     = 3'd2,
        EV_ENTER     = 3'd3,
        EV_AUTO_OK   = 3'd4,
        EV_CONFIRM   = 3'd5
    } event_t;

    typedef struct packed {
        logic [TIME_W-1:0]  auto_delay;
        logic [TIME_W-1:0]  window;
        logic [TALLY_W-1:0] retry_max;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [CODE_W-1:0] fault_code;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]         mode_now;
        logic [CODE_W-1:0]  current_fault;
        logic               recovery_allowed;
        logic               needs_confirm;
        logic               locked_out;
        logic [TALLY_W-1:0] retry_tally_now;
        logic [2:0]         event_code;
    } result_t;

endpackage

`default_nettype wire

[design/frs_cfg.sv]
// frs_cfg: configuration register file of the supervisor
// depends on frs_pkg
`default_nettype none

module frs_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_en,
    input  wire logic [1:0]    wr_index,
    input  wire logic [31:0]   wr_data,
    output frs_pkg::cfg_t      cfg
);
    import frs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                CFG_AUTO_DELAY: cfg_next.auto_delay = wr_data;
                CFG_WINDOW:     cfg_next.window     = wr_data;
                CFG_RETRY_MAX:  cfg_next.retry_max  = wr_data[TALLY_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_delay <= AUTO_DELAY_RST;
            cfg_reg.window     <= WINDOW_RST;
            cfg_reg.retry_max  <= RETRY_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[design/frs_core.sv]
// frs_core: supervisor state and the per-item update logic
// depends on frs_pkg; driven by the input stage of the top level
`default_nettype none

module frs_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  frs_pkg::item_t     item,
    input  frs_pkg::cfg_t      cfg,
    output frs_pkg::result_t   result
);
    import frs_pkg::*;

    mode_t              mode_reg,     mode_next;
    logic [CODE_W-1:0]  fault_reg,    fault_next;
    logic [TIME_W-1:0]  stamp_reg,    stamp_next;
    logic               confirm_reg,  confirm_next;
    logic [CODE_W-1:0]  tracked_reg,  tracked_next;
    logic [TALLY_W-1:0] tally_reg,    tally_next;
    logic [TIME_W-1:0]  wstart_reg,   wstart_next;
    event_t             ev;

    logic               blacklist;
    logic               restart;
    logic [TIME_W-1:0]  since_window;
    logic [TIME_W-1:0]  since_fault;
    logic [TALLY_W-1:0] tally_fault;

    assign blacklist    = item.fault_code inside {[FC_BLACK_FIRST:FC_BLACK_LAST]};
    assign since_window = item.now_ms - wstart_reg;
    assign since_fault  = item.now_ms - stamp_reg;
    assign restart      = (tracked_reg != item.fault_code) || (since_window > cfg.window);

    always_comb begin
        if (restart) begin
            tally_fault = TALLY_W'(1);
        end else if (tally_reg != TALLY_SAT) begin
            tally_fault = tally_reg + TALLY_W'(1);
        end else begin
            tally_fault = tally_reg;
        end
    end

    always_comb begin
        mode_next    = mode_reg;
        fault_next   = fault_reg;
        stamp_next   = stamp_reg;
        confirm_next = confirm_reg;
        tracked_next = tracked_reg;
        tally_next   = tally_reg;
        wstart_next  = wstart_reg;
        ev           = EV_NONE;
        case (item.opcode)
            OP_FAULT: begin
                fault_next   = item.fault_code;
                stamp_next   = item.now_ms;
                confirm_next = 1'b0;
                if (blacklist) begin
                    mode_next = MODE_LOCKOUT;
                    ev        = EV_BLACKLIST;
                end else begin
                    tally_next = tally_fault;
                    if (restart) begin
                        tracked_next = item.fault_code;
                        wstart_next  = item.now_ms;
                    end
                    if (tally_fault > cfg.retry_max) begin
                        mode_next = MODE_LOCKOUT;
                        ev        = EV_RETRY;
                    end else begin
                        ev = EV_ENTER;
                        if (item.fault_code == FC_OVERCURRENT) begin
                            mode_next = MODE_AUTO;
                        end else if (item.fault_code inside {[FC_IBUS_LOST:FC_BLADE_TMO]}) begin
                            mode_next = MODE_MANUAL;
                        end else begin
                            mode_next = MODE_LOCKOUT;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (mode_reg == MODE_AUTO && since_fault >= cfg.auto_delay) begin
                    mode_next  = MODE_NONE;
                    fault_next = FC_NONE;
                    ev         = EV_AUTO_OK;
                end
            end
            OP_CONFIRM: begin
                if (mode_reg == MODE_MANUAL) begin
                    mode_next    = MODE_NONE;
                    fault_next   = FC_NONE;
                    confirm_next = 1'b1;
                    ev           = EV_CONFIRM;
                end
            end
            default: begin
                ev = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_NONE;
            fault_reg   <= FC_NONE;
            stamp_reg   <= '0;
            confirm_reg <= 1'b0;
            tracked_reg <= FC_NONE;
            tally_reg   <= '0;
            wstart_reg  <= '0;
        end else if (step_en) begin
            mode_reg    <= mode_next;
            fault_reg   <= fault_next;
            stamp_reg   <= stamp_next;
            confirm_reg <= confirm_next;
            tracked_reg <= tracked_next;
            tally_reg   <= tally_next;
            wstart_reg  <= wstart_next;
        end
    end

    // status after the item
    always_comb begin
        case (mode_next)
            MODE_NONE:    result.mode_now = MODE_CODE_NONE;
            MODE_AUTO:    result.mode_now = MODE_CODE_AUTO;
            MODE_MANUAL:  result.mode_now = MODE_CODE_MANUAL;
            MODE_LOCKOUT: result.mode_now = MODE_CODE_LOCKOUT;
            default:      result.mode_now = MODE_CODE_LOCKOUT;
        endcase
        result.current_fault    = fault_next;
        result.recovery_allowed = (mode_next == MODE_NONE) || (mode_next == MODE_AUTO) ||
                                  (mode_next == MODE_MANUAL && confirm_next);
        result.needs_confirm    = (mode_next == MODE_MANUAL) && !confirm_next;
        result.locked_out       = (mode_next == MODE_LOCKOUT);
        result.retry_tally_now  = tally_next;
        result.event_code       = ev;
    end

`ifndef SYNTH
    a_blacklist_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.opcode == OP_FAULT && blacklist |=> mode_reg == MODE_LOCKOUT)
        else $error("blacklisted fault did not lock out");

    a_tally_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.opcode == OP_FAULT && !blacklist |=> tally_reg != '0)
        else $error("retry tally zero after counted fault");

    a_idle_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_NONE |-> fault_reg == FC_NONE)
        else $error("fault held with mode none");

    a_manual_unconfirmed: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_MANUAL |-> !confirm_reg)
        else $error("manual mode already confirmed");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(mode_reg) && $stable(tally_reg))
        else $error("state moved without an item");
`endif

endmodule

`default_nettype wire

[design/fault_recovery_supervisor.sv]
// fault_recovery_supervisor: top level with input and result registers
// depends on frs_pkg, frs_cfg and frs_core
//
//  channel | handshake             | payload
//  s_      | s_valid / s_ready     | s_opcode, s_fault_code, s_now_ms
//  m_      | m_valid / m_ready     | m_mode_now .. m_event_code
//  cfg_    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle while m_ready is high; an accepted item is held in the input register,
// and state is updated as it moves from the input register to the result register
// s_ready falls only when both registers are full and m_ready is low
// reset clears all supervisor state and loads the default configuration
// cfg_ready is always high
`default_nettype none

module fault_recovery_supervisor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [3:0]  s_fault_code,
    input  wire logic [31:0] s_now_ms,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_mode_now,
    output logic [3:0]       m_current_fault,
    output logic             m_recovery_allowed,
    output logic             m_needs_confirm,
    output logic             m_locked_out,
    output logic [7:0]       m_retry_tally_now,
    output logic [2:0]       m_event_code,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import frs_pkg::*;

    item_t   item_reg, item_next;
    logic    in_valid_reg, in_valid_next;
    result_t res_reg, res_next;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    cfg_t    cfg;

    assign cfg_ready = 1'b1;

    frs_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    frs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (res_next)
    );

    always_comb begin
        item_next     = item_reg;
        in_valid_next = in_valid_reg && !advance;
        if (s_valid && s_ready) begin
            item_next.opcode     = s_opcode;
            item_next.fault_code = s_fault_code;
            item_next.now_ms     = s_now_ms;
            in_valid_next        = 1'b1;
        end
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_mode_now         = res_reg.mode_now;
    assign m_current_fault    = res_reg.current_fault;
    assign m_recovery_allowed = res_reg.recovery_allowed;
    assign m_needs_confirm    = res_reg.needs_confirm;
    assign m_locked_out       = res_reg.locked_out;
    assign m_retry_tally_now  = res_reg.retry_tally_now;
    assign m_event_code       = res_reg.event_code;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(res_reg))
        else $error("pending result overwritten");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("item lost between stages");
`endif

endmodule

`default_nettype wire
